// ===== hdl/lgrid_pkg.sv =====
// Shared types and constants for the life automaton grid.
// Used by lgrid_row_calc and life_automaton_grid_top; no dependencies.
package lgrid_pkg;

	localparam int MAX_ROWS = 64;
	localparam int MAX_COLS = 64;

	localparam int IDX_W     = 6;
	localparam int CFG_W     = 7;
	localparam int CFG_IDX_W = 1;
	localparam int ROW_W     = $clog2(MAX_ROWS);
	localparam int RCNT_W    = $clog2(MAX_ROWS + 1);
	localparam int CCNT_W    = $clog2(MAX_COLS + 1);
	localparam int EXT_A     = (CFG_W > IDX_W) ? CFG_W : IDX_W;
	localparam int EXT_B     = (RCNT_W > CCNT_W) ? RCNT_W : CCNT_W;
	localparam int EXT_W     = (EXT_A > EXT_B) ? EXT_A : EXT_B;

	localparam logic [CFG_W-1:0] CFG_RESET = 7'd64;

	localparam logic [CFG_IDX_W-1:0] REG_ROWS_USED = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_COLS_USED = 1'd1;

	localparam logic [3:0] LIVE_KEEP = 4'd2;
	localparam logic [3:0] LIVE_BORN = 4'd3;

	typedef enum logic [2:0] {
		REQ_WRITE = 3'd0,
		REQ_READ  = 3'd1,
		REQ_STEP  = 3'd2,
		REQ_CLEAR = 3'd3,
		REQ_FILL  = 3'd4
	} req_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CELL,
		ST_SWEEP,
		ST_RESP
	} state_t;

endpackage

// ===== hdl/life_automaton_grid_top.sv =====
// Top level of the life automaton grid: request sequencer, row memory and step pipeline.
// Depends on lgrid_pkg, lgrid_ram and lgrid_row_calc.
//
// A request word is taken on a rising edge where start is high and busy is low.
// Every request gives exactly one result word, shown for one cycle with done high;
// the receiver cannot hold it off. cfg_we writes rows_used (index 0) or
// cols_used (index 1) from cfg_data; writes must be made only while busy is low,
// which the block itself does not enforce. Write and read cell requests read the
// row word from the memory, then modify, write back and report. Clear and fill do
// one read-modify-write of a row word per cycle through the single read and single
// write port of the row memory. A step streams rows out of the memory one per cycle;
// each new row is computed once the row below it has arrived, and the last row is
// computed in a flush step with a dead row below it. Unknown requests and requests
// on an empty area go straight to the response; out-of-range cell accesses answer
// with index_error set. The block works on one request at a time.
// Reset clears the state machine, sets both size registers to 64 and marks every
// row word as dead through per-row valid bits, so no clearing pass is needed.
module life_automaton_grid_top (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	output logic                             busy,
	input  logic [2:0]                       req_type,
	input  logic [lgrid_pkg::IDX_W-1:0]      row_index,
	input  logic [lgrid_pkg::IDX_W-1:0]      col_index,
	input  logic                             write_value,
	output logic                             done,
	output logic                             cell_value,
	output logic                             index_error,
	input  logic                             cfg_we,
	input  logic [lgrid_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  logic [lgrid_pkg::CFG_W-1:0]      cfg_data
);

	localparam int W = lgrid_pkg::MAX_COLS;

	lgrid_pkg::state_t state_q, state_d;
	lgrid_pkg::req_t   req, op_q;

	logic [lgrid_pkg::CFG_W-1:0]  rows_used_q, cols_used_q;
	logic [lgrid_pkg::RCNT_W-1:0] eff_rows;
	logic [lgrid_pkg::CCNT_W-1:0] eff_cols;
	logic [W-1:0]                 col_mask;
	logic                         area_empty;

	logic                         accept, acc_err;
	logic [lgrid_pkg::IDX_W-1:0]  row_q, col_q;
	logic                         wv_q, err_q;
	logic [W-1:0]                 col_bit;

	logic                         rd_en, wr_en;
	logic [lgrid_pkg::ROW_W-1:0]  rd_addr, wr_addr;
	logic [W-1:0]                 rd_data, rd_word, wr_data;
	logic [lgrid_pkg::MAX_ROWS-1:0] valid_q;
	logic                         rd_vld_s1;

	logic                         sweep_rd, last_s1, flush_q, rvalid_s1;
	logic [lgrid_pkg::RCNT_W-1:0] rd_cnt_q;
	logic [lgrid_pkg::ROW_W-1:0]  rrow_s1, cur_row_q;
	logic [W-1:0]                 cur_q, above_q, calc_below, calc_next;

	assign req = lgrid_pkg::req_t'(req_type);

	assign eff_rows = (lgrid_pkg::EXT_W'(rows_used_q) > lgrid_pkg::EXT_W'(lgrid_pkg::MAX_ROWS))
		? lgrid_pkg::RCNT_W'(lgrid_pkg::MAX_ROWS) : lgrid_pkg::RCNT_W'(rows_used_q);
	assign eff_cols = (lgrid_pkg::EXT_W'(cols_used_q) > lgrid_pkg::EXT_W'(lgrid_pkg::MAX_COLS))
		? lgrid_pkg::CCNT_W'(lgrid_pkg::MAX_COLS) : lgrid_pkg::CCNT_W'(cols_used_q);
	assign area_empty = (eff_rows == '0) || (eff_cols == '0);

	for (genvar c = 0; c < W; c++) begin : g_mask
		assign col_mask[c] = lgrid_pkg::EXT_W'(c) < lgrid_pkg::EXT_W'(eff_cols);
	end

	assign busy   = (state_q != lgrid_pkg::ST_IDLE);
	assign accept = start && !busy;
	assign acc_err = (lgrid_pkg::EXT_W'(row_index) >= lgrid_pkg::EXT_W'(eff_rows))
		|| (lgrid_pkg::EXT_W'(col_index) >= lgrid_pkg::EXT_W'(eff_cols));

	assign col_bit = {{(W-1){1'b0}}, 1'b1} << col_q;
	assign rd_word = rd_vld_s1 ? rd_data : '0;

	assign sweep_rd = (state_q == lgrid_pkg::ST_SWEEP) && !flush_q && (rd_cnt_q < eff_rows);
	assign last_s1  = rvalid_s1
		&& ((lgrid_pkg::RCNT_W'(rrow_s1) + lgrid_pkg::RCNT_W'(1)) == eff_rows);

	assign rd_en   = accept || sweep_rd;
	assign rd_addr = accept ? lgrid_pkg::ROW_W'(row_index) : rd_cnt_q[lgrid_pkg::ROW_W-1:0];

	assign calc_below = flush_q ? '0 : (rd_word & col_mask);

	lgrid_row_calc u_calc (
		.above (above_q),
		.cur   (cur_q & col_mask),
		.below (calc_below),
		.mask  (col_mask),
		.next  (calc_next)
	);

	lgrid_ram #(
		.WIDTH (W),
		.DEPTH (lgrid_pkg::MAX_ROWS)
	) u_rows (
		.clk   (clk),
		.we    (wr_en),
		.waddr (wr_addr),
		.wdata (wr_data),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	always_comb begin
		state_d = state_q;
		wr_en   = 1'b0;
		wr_addr = cur_row_q;
		wr_data = (cur_q & ~col_mask) | calc_next;
		case (state_q)
			lgrid_pkg::ST_IDLE: begin
				if (start) begin
					case (req)
						lgrid_pkg::REQ_WRITE, lgrid_pkg::REQ_READ: state_d = lgrid_pkg::ST_CELL;
						lgrid_pkg::REQ_STEP, lgrid_pkg::REQ_CLEAR, lgrid_pkg::REQ_FILL: begin
							state_d = area_empty ? lgrid_pkg::ST_RESP : lgrid_pkg::ST_SWEEP;
						end
						default: state_d = lgrid_pkg::ST_RESP;
					endcase
				end
			end
			lgrid_pkg::ST_CELL: begin
				wr_en   = (op_q == lgrid_pkg::REQ_WRITE) && !err_q;
				wr_addr = lgrid_pkg::ROW_W'(row_q);
				wr_data = wv_q ? (rd_word | col_bit) : (rd_word & ~col_bit);
				state_d = lgrid_pkg::ST_IDLE;
			end
			lgrid_pkg::ST_SWEEP: begin
				if (op_q == lgrid_pkg::REQ_STEP) begin
					wr_en = flush_q || (rvalid_s1 && (rrow_s1 != '0));
					if (flush_q) begin
						state_d = lgrid_pkg::ST_RESP;
					end
				end else begin
					wr_en   = rvalid_s1;
					wr_addr = rrow_s1;
					wr_data = (op_q == lgrid_pkg::REQ_FILL) ? (rd_word | col_mask)
						: (rd_word & ~col_mask);
					if (last_s1) begin
						state_d = lgrid_pkg::ST_RESP;
					end
				end
			end
			lgrid_pkg::ST_RESP: state_d = lgrid_pkg::ST_IDLE;
			default: state_d = lgrid_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= lgrid_pkg::ST_IDLE;
			rows_used_q <= lgrid_pkg::CFG_RESET;
			cols_used_q <= lgrid_pkg::CFG_RESET;
			valid_q     <= '0;
			rd_cnt_q    <= '0;
			rvalid_s1   <= 1'b0;
			flush_q     <= 1'b0;
		end else begin
			state_q   <= state_d;
			rvalid_s1 <= sweep_rd;
			if (cfg_we) begin
				case (cfg_idx)
					lgrid_pkg::REG_ROWS_USED: rows_used_q <= cfg_data;
					lgrid_pkg::REG_COLS_USED: cols_used_q <= cfg_data;
					default: ;
				endcase
			end
			if (wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end
			if (accept) begin
				rd_cnt_q <= '0;
			end else if (sweep_rd) begin
				rd_cnt_q <= rd_cnt_q + lgrid_pkg::RCNT_W'(1);
			end
			if (flush_q) begin
				flush_q <= 1'b0;
			end else if ((state_q == lgrid_pkg::ST_SWEEP) && (op_q == lgrid_pkg::REQ_STEP)
					&& last_s1) begin
				flush_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q  <= req;
			row_q <= row_index;
			col_q <= col_index;
			wv_q  <= write_value;
			err_q <= acc_err;
		end
		if (rd_en) begin
			rd_vld_s1 <= valid_q[rd_addr];
		end
		rrow_s1 <= rd_cnt_q[lgrid_pkg::ROW_W-1:0];
		if (rvalid_s1 && (op_q == lgrid_pkg::REQ_STEP)) begin
			cur_q     <= rd_word;
			cur_row_q <= rrow_s1;
			above_q   <= (rrow_s1 == '0) ? '0 : (cur_q & col_mask);
		end
	end

	assign done        = (state_q == lgrid_pkg::ST_CELL) || (state_q == lgrid_pkg::ST_RESP);
	assign index_error = (state_q == lgrid_pkg::ST_CELL) && err_q;
	assign cell_value  = (state_q == lgrid_pkg::ST_CELL) && (op_q == lgrid_pkg::REQ_READ)
		&& !err_q && |(rd_word & col_bit);

`ifndef SYNTH
	a_no_same_row: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en && rd_en |-> wr_addr != rd_addr)
		else $error("row read and written in the same cycle");

	a_err_word: assert property (@(posedge clk) disable iff (!arst_n)
		index_error |-> done && !cell_value)
		else $error("error word carries a cell value");

	a_flush_step: assert property (@(posedge clk) disable iff (!arst_n)
		flush_q |-> (state_q == lgrid_pkg::ST_SWEEP) && (op_q == lgrid_pkg::REQ_STEP))
		else $error("flush outside a step sweep");

	a_row_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rvalid_s1 |-> lgrid_pkg::RCNT_W'(rrow_s1) < eff_rows)
		else $error("sweep read beyond used rows");

	a_busy_after: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy)
		else $error("accepted word did not raise busy");
`endif

endmodule

// ===== hdl/lgrid_ram.sv =====
// Generic single-clock RAM with one write port and one registered read port.
// No dependencies.
module lgrid_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== hdl/lgrid_row_calc.sv =====
// Next-generation value of one grid row from the rows above, at and below it.
// Depends on lgrid_pkg.
module lgrid_row_calc (
	input  logic [lgrid_pkg::MAX_COLS-1:0] above,
	input  logic [lgrid_pkg::MAX_COLS-1:0] cur,
	input  logic [lgrid_pkg::MAX_COLS-1:0] below,
	input  logic [lgrid_pkg::MAX_COLS-1:0] mask,
	output logic [lgrid_pkg::MAX_COLS-1:0] next
);

	logic [lgrid_pkg::MAX_COLS-1:0] above_l, above_r, cur_l, cur_r, below_l, below_r;

	assign above_l = above << 1;
	assign above_r = above >> 1;
	assign cur_l   = cur << 1;
	assign cur_r   = cur >> 1;
	assign below_l = below << 1;
	assign below_r = below >> 1;

	for (genvar c = 0; c < lgrid_pkg::MAX_COLS; c++) begin : g_col
		logic [3:0] n;
		assign n = 4'(above_l[c]) + 4'(above[c]) + 4'(above_r[c])
			+ 4'(cur_l[c]) + 4'(cur_r[c])
			+ 4'(below_l[c]) + 4'(below[c]) + 4'(below_r[c]);
		assign next[c] = mask[c]
			& ((n == lgrid_pkg::LIVE_BORN) | (cur[c] & (n == lgrid_pkg::LIVE_KEEP)));
	end

endmodule
